FILE: src/lch_pkg.sv
// Shared constants, types and functions for the log2 cumulative histogram.
`default_nettype none

package lch_pkg;

    localparam int NUM_BINS     = 32;
    localparam int SAMPLE_WIDTH = 32;

    localparam int CMD_W        = 1;
    localparam int VALUE_W      = 32;
    localparam int INDEX_W      = 5;
    localparam int BOUND_W      = 31;
    localparam int COUNT_W      = 48;
    localparam int SUM_W        = 64;

    localparam int BIN_IDX_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_ACCUMULATE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

    typedef logic [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [NUM_BINS-1:0]     bin_mask_t;
    typedef logic [BIN_IDX_W-1:0]    bin_idx_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        sample_t          sample;
        bin_mask_t        above;
    } lch_item_t;

    function automatic logic [63:0] bin_threshold(input int unsigned idx);
        logic [63:0] t;
        begin
            t = 64'd0;
            if (idx != 0)
            begin
                t = 64'd1 << (idx - 1);
            end
            return t;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/lch_if.sv
// Valid/ready channel interfaces for sample input and bin report output.
`default_nettype none

interface lch_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [lch_pkg::CMD_W-1:0]             cmd;
    logic [lch_pkg::VALUE_W-1:0]           sample_value;

    modport source (output valid, output cmd, output sample_value, input ready);
    modport sink   (input valid, input cmd, input sample_value, output ready);
endinterface

interface lch_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [lch_pkg::INDEX_W-1:0]           bin_index;
    logic [lch_pkg::BOUND_W-1:0]           lower_bound;
    logic [lch_pkg::COUNT_W-1:0]           bin_count;
    logic [lch_pkg::SUM_W-1:0]             bin_sum;
    logic                                  last_bin;

    modport source (output valid, output bin_index, output lower_bound, output bin_count,
                    output bin_sum, output last_bin, input ready);
    modport sink   (input valid, input bin_index, input lower_bound, input bin_count,
                    input bin_sum, input last_bin, output ready);
endinterface

`default_nettype wire

FILE: src/lch_front.sv
// Front end: accept input transfers and classify each sample against all bin thresholds.
`default_nettype none

module lch_front (
    lch_in_if.sink              in_ch,
    output logic                push_valid,
    output lch_pkg::lch_item_t  push_item,
    input  logic                push_ready
);
    import lch_pkg::*;

    sample_t   sample;
    bin_mask_t above;

    assign sample = sample_t'(in_ch.sample_value[SAMPLE_WIDTH-1:0]);

    always_comb
    begin
        for (int i = 0; i < NUM_BINS; i++)
        begin
            above[i] = ({{(64-SAMPLE_WIDTH){1'b0}}, sample} > bin_threshold(i));
        end
    end

    assign in_ch.ready      = push_ready;
    assign push_valid       = in_ch.valid;
    assign push_item.cmd    = in_ch.cmd;
    assign push_item.sample = sample;
    assign push_item.above  = above;

endmodule

`default_nettype wire

FILE: src/lch_queue.sv
// Short queue between the front end and the bin engine.
`default_nettype none

module lch_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  lch_pkg::lch_item_t  push_item,
    output logic                push_ready,
    output logic                pop_valid,
    output lch_pkg::lch_item_t  pop_item,
    input  logic                pop_ready
);
    import lch_pkg::*;

    lch_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/lch_back.sv
// Bin engine: per-bin saturating count and sum lanes, and the dump sequencer.
`default_nettype none

module lch_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    input  lch_pkg::lch_item_t  pop_item,
    output logic                pop_ready,
    lch_out_if.source           out_ch
);
    import lch_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    state_t               state_reg;
    bin_idx_t             idx_reg;
    logic [COUNT_W-1:0]   count_reg [NUM_BINS];
    logic [SUM_W-1:0]     sum_reg   [NUM_BINS];

    logic                 out_valid_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic [BOUND_W-1:0]   out_bound_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic [SUM_W-1:0]     out_sum_reg;
    logic                 out_last_reg;

    logic                 take;
    logic                 accumulate;
    logic                 out_free;
    logic [63:0]          bound_full;
    logic [SUM_W:0]       sum_wide [NUM_BINS];

    assign pop_ready  = (state_reg == ST_IDLE);
    assign take       = pop_valid && pop_ready;
    assign accumulate = take && (pop_item.cmd == CMD_ACCUMULATE);
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign bound_full = bin_threshold(32'(idx_reg));

    always_comb
    begin
        for (int i = 0; i < NUM_BINS; i++)
        begin
            sum_wide[i] = {1'b0, sum_reg[i]} + (SUM_W+1)'(pop_item.sample);
        end
    end

    generate
        for (genvar g = 0; g < NUM_BINS; g++)
        begin : g_lane
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    count_reg[g] <= '0;
                    sum_reg[g]   <= '0;
                end
                else if (accumulate && pop_item.above[g])
                begin
                    if (count_reg[g] != COUNT_MAX)
                    begin
                        count_reg[g] <= count_reg[g] + 1'b1;
                    end
                    sum_reg[g] <= sum_wide[g][SUM_W] ? SUM_MAX : sum_wide[g][SUM_W-1:0];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_bound_reg <= '0;
            out_count_reg <= '0;
            out_sum_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take && (pop_item.cmd == CMD_DUMP))
                    begin
                        state_reg <= ST_DUMP;
                        idx_reg   <= '0;
                    end
                end
                ST_DUMP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_index_reg <= INDEX_W'(idx_reg);
                        out_bound_reg <= bound_full[BOUND_W-1:0];
                        out_count_reg <= count_reg[idx_reg];
                        out_sum_reg   <= sum_reg[idx_reg];
                        if (idx_reg == BIN_IDX_W'(NUM_BINS - 1))
                        begin
                            out_last_reg <= 1'b1;
                            state_reg    <= ST_IDLE;
                        end
                        else
                        begin
                            out_last_reg <= 1'b0;
                            idx_reg      <= idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.bin_index   = out_index_reg;
    assign out_ch.lower_bound = out_bound_reg;
    assign out_ch.bin_count   = out_count_reg;
    assign out_ch.bin_sum     = out_sum_reg;
    assign out_ch.last_bin    = out_last_reg;

endmodule

`default_nettype wire

FILE: src/log2_cumulative_histogram.sv
// Top level: log2 cumulative histogram with a classifying front end, queue and bin engine.
// A new sample is accepted every cycle while the engine is idle and the queue has room.
// A dump emits NUM_BINS results via ST_DUMP, one bin per cycle while out_ch.ready is high.
// The dump sequencer holds further items in the queue until the last bin is registered.
// Reset clears every bin count and sum, the queue and the output register at once.
`default_nettype none

module log2_cumulative_histogram (
    input  logic     clk,
    input  logic     rst_n,
    lch_in_if.sink   in_ch,
    lch_out_if.source out_ch
);
    import lch_pkg::*;

    logic      push_valid;
    logic      push_ready;
    lch_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    lch_item_t pop_item;

    lch_front u_front (
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    lch_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    lch_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire
